// File: hdl/pabu_pkg.sv
// Shared types and constants for the point angle core: fixed-point formats,
// the arctangent table in units of pi/2^33 and the pipeline flag bundle.
// Depends on nothing; used by point_angle_binary_units_core.
package pabu_pkg;

    // Fractional guard bits below the coordinate LSB inside the rotator.
    localparam int GUARD = 24;
    // Number of arctangent table entries.
    localparam int TAB_LEN = 24;
    // Table entries are unsigned and never exceed a quarter turn of pi.
    localparam int ATAN_W = 32;
    // Signed angle accumulator, wide enough for the sum of every entry.
    localparam int ZW = ATAN_W + 2;
    // Unsigned angle after unfolding, up to and including pi.
    localparam int THETA_W = 34;
    // Result angle, 512 equals pi.
    localparam int ANGLE_W = 11;
    localparam int MAG_W = ANGLE_W - 1;
    localparam int M_TDATA_W = 16;

    localparam logic signed [ZW-1:0]  Z_QUARTER_PI = 34'sh0_8000_0000;
    localparam logic [ATAN_W-1:0]     T_QUARTER_PI = 32'h8000_0000;
    localparam logic [THETA_W-1:0]    THETA_HALF_PI = 34'h1_0000_0000;
    localparam logic [THETA_W-1:0]    THETA_PI = 34'h2_0000_0000;

    // Octant folding flags that travel with each word down the pipeline.
    typedef struct packed {
        logic swapped;
        logic dx_neg;
        logic dy_neg;
        logic is_zero;
        logic is_diag;
    } pabu_flags_t;

    // round(atan(2^-i) * 2^33 / pi)
    function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            0:       val = 32'd2147483648;
            1:       val = 32'd1267733622;
            2:       val = 32'd669835629;
            3:       val = 32'd340019024;
            4:       val = 32'd170669324;
            5:       val = 32'd85417861;
            6:       val = 32'd42719353;
            7:       val = 32'd21360980;
            8:       val = 32'd10680653;
            9:       val = 32'd5340347;
            10:      val = 32'd2670176;
            11:      val = 32'd1335088;
            12:      val = 32'd667544;
            13:      val = 32'd333772;
            14:      val = 32'd166886;
            15:      val = 32'd83443;
            16:      val = 32'd41722;
            17:      val = 32'd20861;
            18:      val = 32'd10430;
            19:      val = 32'd5215;
            20:      val = 32'd2608;
            21:      val = 32'd1304;
            22:      val = 32'd652;
            23:      val = 32'd326;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: hdl/point_angle_binary_units_core.sv
// Top level of the point angle core: a pipelined vectoring CORDIC that gives
// atan2 of the difference of two points in binary angle units (pi = 512).
// Depends on pabu_pkg for formats, flags and the arctangent table.
//
// Usage: each input word on the s_ channel carries two points; each output
// word on the m_ channel carries one signed angle, the direction from the
// reference point (to_x, to_y) to the first point (from_x, from_y), scaled so
// that 512 equals pi and truncated toward zero. A word is moved on a rising
// edge of aclk where tvalid and tready are both high.
// Pipeline steps from acceptance to m_tvalid, in order: one forms the
// differences, one folds them into the first octant, one per rotation stage
// (18 with the default CORDIC_STAGES), one clamps and resolves the special
// cases, and one registers the unfolded result.
// Throughput is one word per cycle while the skid register is empty; every
// stage takes a new word each cycle, set by the one rotation per stage.
// When the receiver stalls, the output register holds its word and a one-word
// skid register catches the word leaving the pipeline, so one more word is
// still accepted; after that the whole pipeline freezes and s_tready drops.
// s_tready comes straight from a register. A synchronous low on aresetn
// empties the pipeline, the output and the skid register.
module point_angle_binary_units_core #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata, lowest bit up: from_x, from_y, to_x, to_y (COORD_WIDTH each)
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata, lowest bit up: angle (11 bits), then zero fill
    output logic [pabu_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready
);

    localparam int CW     = COORD_WIDTH;
    localparam int DIFF_W = CW + 1;
    localparam int N      = CORDIC_STAGES;
    // Rotator width: coordinate magnitude, growth from the CORDIC gain and the
    // first rotation, a sign bit and the guard bits.
    localparam int DW     = CW + pabu_pkg::GUARD + 3;
    localparam int PAD_W  = DW - CW - pabu_pkg::GUARD;
    // Pipeline stages ahead of the output register: difference, fold,
    // rotations and the final clamp.
    localparam int NV     = N + 3;
    localparam int T_IDX  = NV - 1;

    // Whole pipeline moves together while the skid register is empty.
    logic pipe_en;
    logic [NV-1:0] vld_reg;

    // Stage 0: differences.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dx_next, dy_next;

    // Stage 1: folded magnitudes and flags.
    logic [CW-1:0] ax_reg, ay_reg, ax_next, ay_next;
    pabu_pkg::pabu_flags_t f1_reg, f1_next;

    // Rotation stages.
    logic signed [DW-1:0]          x_reg [N];
    logic signed [DW-1:0]          y_reg [N];
    logic signed [pabu_pkg::ZW-1:0] z_reg [N];
    pabu_pkg::pabu_flags_t         fc_reg [N];
    logic signed [DW-1:0]          x_next [N];
    logic signed [DW-1:0]          y_next [N];
    logic signed [pabu_pkg::ZW-1:0] z_next [N];
    logic signed [DW-1:0]          x_src [N];
    logic signed [DW-1:0]          y_src [N];
    logic signed [pabu_pkg::ZW-1:0] z_src [N];
    pabu_pkg::pabu_flags_t         fc_src [N];

    // Clamp stage.
    logic [pabu_pkg::ATAN_W-1:0] t_reg, t_next;
    pabu_pkg::pabu_flags_t ft_reg;

    // Unfolded result and the output side.
    logic [pabu_pkg::ANGLE_W-1:0] angle_next;
    logic [pabu_pkg::ANGLE_W-1:0] out_data_reg, skid_data_reg;
    logic out_vld_reg, skid_vld_reg;
    logic pipe_out;

    assign pipe_en  = !skid_vld_reg;
    assign s_tready = pipe_en;
    assign pipe_out = vld_reg[T_IDX] && pipe_en;

    // Differences are exact in one extra bit.
    always_comb begin
        dx_next = signed'({s_tdata[CW-1], s_tdata[CW-1:0]})
                - signed'({s_tdata[3*CW-1], s_tdata[3*CW-1:2*CW]});
        dy_next = signed'({s_tdata[2*CW-1], s_tdata[2*CW-1:CW]})
                - signed'({s_tdata[4*CW-1], s_tdata[4*CW-1:3*CW]});
    end

    // Fold into the first octant: take magnitudes and put the larger in x.
    always_comb begin
        logic signed [DIFF_W-1:0] dx_abs, dy_abs;
        logic [CW-1:0] mx, my;
        logic swap;
        dx_abs = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
        dy_abs = dy_reg[DIFF_W-1] ? -dy_reg : dy_reg;
        mx     = dx_abs[CW-1:0];
        my     = dy_abs[CW-1:0];
        swap   = my > mx;
        ax_next = swap ? my : mx;
        ay_next = swap ? mx : my;
        f1_next.swapped = swap;
        f1_next.dx_neg  = dx_reg[DIFF_W-1];
        f1_next.dy_neg  = dy_reg[DIFF_W-1];
        f1_next.is_zero = (swap ? mx : my) == '0;
        f1_next.is_diag = mx == my;
    end

    // One vectoring rotation per stage; each stage reads the one before it.
    always_comb begin
        logic signed [DW-1:0] xs, ys;
        x_src[0]  = signed'({{PAD_W{1'b0}}, ax_reg, {pabu_pkg::GUARD{1'b0}}});
        y_src[0]  = signed'({{PAD_W{1'b0}}, ay_reg, {pabu_pkg::GUARD{1'b0}}});
        z_src[0]  = '0;
        fc_src[0] = f1_reg;
        for (int i = 1; i < N; i++) begin
            x_src[i]  = x_reg[i-1];
            y_src[i]  = y_reg[i-1];
            z_src[i]  = z_reg[i-1];
            fc_src[i] = fc_reg[i-1];
        end
        for (int i = 0; i < N; i++) begin
            xs = x_src[i] >>> i;
            ys = y_src[i] >>> i;
            if (!y_src[i][DW-1]) begin
                x_next[i] = x_src[i] + ys;
                y_next[i] = y_src[i] - xs;
                z_next[i] = z_src[i] + signed'({2'b00, pabu_pkg::atan_entry(i)});
            end else begin
                x_next[i] = x_src[i] - ys;
                y_next[i] = y_src[i] + xs;
                z_next[i] = z_src[i] - signed'({2'b00, pabu_pkg::atan_entry(i)});
            end
        end
    end

    // Axis and diagonal cases bypass the rotator; otherwise clamp to an octant.
    always_comb begin
        priority if (fc_reg[N-1].is_zero) begin
            t_next = '0;
        end else if (fc_reg[N-1].is_diag) begin
            t_next = pabu_pkg::T_QUARTER_PI;
        end else if (z_reg[N-1] < 0) begin
            t_next = '0;
        end else if (z_reg[N-1] > pabu_pkg::Z_QUARTER_PI) begin
            t_next = pabu_pkg::T_QUARTER_PI;
        end else begin
            t_next = z_reg[N-1][pabu_pkg::ATAN_W-1:0];
        end
    end

    // Unfold the octant with a single add: the base is 0, pi/2 or pi, and the
    // folded angle is subtracted when exactly one reflection applies.
    always_comb begin
        logic [pabu_pkg::THETA_W-1:0] base, tz, theta;
        logic [pabu_pkg::MAG_W-1:0] mag;
        base = ft_reg.swapped ? pabu_pkg::THETA_HALF_PI
             : (ft_reg.dx_neg ? pabu_pkg::THETA_PI : '0);
        tz   = {2'b00, t_reg};
        theta = (ft_reg.swapped ^ ft_reg.dx_neg) ? base - tz : base + tz;
        mag  = theta[pabu_pkg::THETA_W-1 -: pabu_pkg::MAG_W];
        angle_next = ft_reg.dy_neg ? -{1'b0, mag} : {1'b0, mag};
    end

    // Pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            f1_reg <= f1_next;
            for (int i = 0; i < N; i++) begin
                x_reg[i]  <= x_next[i];
                y_reg[i]  <= y_next[i];
                z_reg[i]  <= z_next[i];
                fc_reg[i] <= fc_src[i];
            end
            t_reg  <= t_next;
            ft_reg <= fc_reg[N-1];
        end
    end

    // Output register with a one-word skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= pipe_out;
            end
        end else if (pipe_out) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : angle_next;
        end else if (pipe_out) begin
            skid_data_reg <= angle_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(pabu_pkg::M_TDATA_W - pabu_pkg::ANGLE_W){1'b0}}, out_data_reg};

endmodule
